// ----- design/gsls_pkg.sv -----
`default_nettype none

package gsls_pkg;

    localparam int TABLE_ENTRIES = 128;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);

    localparam logic [15:0] RESET_PROB = 16'd9830;
    localparam logic [32:0] ONE_Q32    = 33'h1_0000_0000;
    localparam logic [31:0] MAX_LEN    = 32'hFFFF_FFFF;

    localparam logic REG_RESTART_PROB = 1'b0;

    // word travelling along the compare chain
    typedef struct packed {
        logic             valid;
        logic [15:0]      sample;
        logic             found;
        logic [IDX_W-1:0] idx;
    } t_token;

    // table fill stream from the builder into the chain
    typedef struct packed {
        logic        load;
        logic [15:0] entry;
    } t_fill;

endpackage

`default_nettype wire

// ----- design/gsls_cell.sv -----
`default_nettype none

module gsls_cell (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_advance,
    input  wire                 i_load,
    input  wire  [15:0]         i_entry,
    output logic [15:0]         o_entry,
    input  gsls_pkg::t_token    i_tok,
    output gsls_pkg::t_token    o_tok
);

    logic [15:0]      r_entry;
    gsls_pkg::t_token r_tok;
    gsls_pkg::t_token n_tok;
    logic             w_hit;

    assign w_hit = i_tok.found || (r_entry >= i_tok.sample);

    always_comb begin
        n_tok       = i_tok;
        n_tok.found = w_hit;
        // count cells passed until the first entry not below the sample
        if (!w_hit) begin
            n_tok.idx = i_tok.idx + gsls_pkg::IDX_W'(1);
        end
    end

    // table entries shift towards cell 0 while the builder fills
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_entry <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else if (i_advance) begin
            r_tok <= n_tok;
        end
    end

    assign o_entry = r_entry;
    assign o_tok   = r_tok;

endmodule

`default_nettype wire

// ----- design/gsls_build.sv -----
`default_nettype none

module gsls_build (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_start,
    input  wire  [15:0]         i_prob,
    output gsls_pkg::t_fill     o_fill
);

    logic [32:0]                r_surv;
    logic [gsls_pkg::IDX_W-1:0] r_cnt;
    logic                       r_busy;
    logic [16:0]                w_keep;
    logic [49:0]                w_prod;
    logic [32:0]                w_surv_next;
    logic [32:0]                w_diff;

    assign w_keep      = 17'h1_0000 - {1'b0, i_prob};
    assign w_prod      = 50'(r_surv) * 50'(w_keep);
    assign w_surv_next = w_prod[48:16];
    assign w_diff      = gsls_pkg::ONE_Q32 - w_surv_next;

    always_comb begin
        o_fill.load = r_busy;
        // saturate when survival has dropped to zero
        if (w_diff[32]) begin
            o_fill.entry = 16'hFFFF;
        end else begin
            o_fill.entry = w_diff[31:16];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
            r_surv <= gsls_pkg::ONE_Q32;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
            r_surv <= gsls_pkg::ONE_Q32;
        end else if (r_busy) begin
            r_surv <= w_surv_next;
            r_cnt  <= r_cnt + gsls_pkg::IDX_W'(1);
            if (r_cnt == gsls_pkg::IDX_W'(gsls_pkg::TABLE_ENTRIES - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ----- design/geometric_step_length_sampler.sv -----
// Geometric step-length sampler by inverse CDF. A uniform Q0.16 word enters a
// chain of 128 compare cells, one table entry per cell, and moves one cell per
// cycle while the output is not stalled; a new word can be taken every cycle
// unless the output stalls or the table is being rebuilt, and its outcome
// passes the 128 cell registers and then the output register. A sample above
// the last entry produces no result and adds 128 to the running offset;
// otherwise the result is offset plus the first index whose entry is not below
// the sample (saturating at 2^32-1) and the offset returns to one. After reset
// and after each write of restart_prob (byte address 0) the table is rebuilt by
// a single 33x17 multiplier, one entry per cycle, accepting no input meanwhile.
`default_nettype none

module geometric_step_length_sampler (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  wire         i_in_valid,
    output logic        o_in_ready,
    input  wire  [15:0] i_uniform_sample,
    output logic        o_out_valid,
    input  wire         i_out_ready,
    output logic [31:0] o_step_length
);

    localparam int N = gsls_pkg::TABLE_ENTRIES;

    logic [15:0]      r_prob;
    logic             r_out_valid;
    logic [31:0]      r_len;
    logic [31:0]      r_offset;
    logic             w_wr;
    logic             w_advance;
    logic [32:0]      w_sum_hit;
    logic [32:0]      w_sum_miss;
    gsls_pkg::t_fill  w_fill;
    gsls_pkg::t_token w_tok [0:N];
    logic [15:0]      w_ent [0:N-1];

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && (paddr[2] == gsls_pkg::REG_RESTART_PROB);
    assign prdata = (paddr[2] == gsls_pkg::REG_RESTART_PROB) ? {16'h0000, r_prob} : 32'h0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prob <= gsls_pkg::RESET_PROB;
        end else if (w_wr) begin
            r_prob <= pwdata[15:0];
        end
    end

    gsls_build u_build (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_wr),
        .i_prob  (r_prob),
        .o_fill  (w_fill)
    );

    // the whole chain holds while a result waits at the output
    assign w_advance  = !r_out_valid || i_out_ready;
    assign o_in_ready = w_advance && !w_fill.load;

    always_comb begin
        w_tok[0].valid  = i_in_valid && o_in_ready;
        w_tok[0].sample = i_uniform_sample;
        w_tok[0].found  = 1'b0;
        w_tok[0].idx    = '0;
    end

    for (genvar k = 0; k < N; k++) begin : g_cell
        logic [15:0] w_in_entry;
        if (k == N - 1) begin : g_last
            assign w_in_entry = w_fill.entry;
        end else begin : g_mid
            assign w_in_entry = w_ent[k+1];
        end
        gsls_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_advance (w_advance),
            .i_load    (w_fill.load),
            .i_entry   (w_in_entry),
            .o_entry   (w_ent[k]),
            .i_tok     (w_tok[k]),
            .o_tok     (w_tok[k+1])
        );
    end

    assign w_sum_hit  = {1'b0, r_offset} + 33'(w_tok[N].idx);
    assign w_sum_miss = {1'b0, r_offset} + 33'(N);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_offset    <= 32'd1;
        end else if (w_advance) begin
            r_out_valid <= w_tok[N].valid && w_tok[N].found;
            if (w_tok[N].valid) begin
                if (w_tok[N].found) begin
                    r_offset <= 32'd1;
                end else begin
                    // miss: grow the offset, hold at the maximum
                    r_offset <= w_sum_miss[32] ? gsls_pkg::MAX_LEN : w_sum_miss[31:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_tok[N].valid && w_tok[N].found) begin
            r_len <= w_sum_hit[32] ? gsls_pkg::MAX_LEN : w_sum_hit[31:0];
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_step_length = r_len;

endmodule

`default_nettype wire
